### design/ldf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_pkg
// Types and the fold table shared by the Latin diacritic fold block.
// ----------------------------------------------------------------------------
package ldf_pkg;

  localparam int CpWidth = 21;

  typedef logic [CpWidth-1:0] cp_t;

  // First and last code point covered by the fold table
  localparam cp_t FoldLo = 21'h0000C0;
  localparam cp_t FoldHi = 21'h00017F;

  localparam int FoldLen = 192;

  // Table marker for a code point that is left as it is
  localparam logic [7:0] NoFold = 8'h2E;

  // One ASCII character per code point from U+00C0, leftmost first
  localparam logic [8*FoldLen-1:0] FoldMap = {
    "AAAAAAACEEEEIIII",  // U+00C0
    "DNOOOOO.OUUUUYTs",  // U+00D0
    "aaaaaaaceeeeiiii",  // U+00E0
    "dnooooo.ouuuuyty",  // U+00F0
    "AaAaAaCcCcCcCcDd",  // U+0100
    "DdEeEeEeEeEeGgGg",  // U+0110
    "GgGgHhHhIiIiIiIi",  // U+0120
    "Ii..JjKkkLlLlLlL",  // U+0130
    "lLlNnNnNnnNnOoOo",  // U+0140
    "OoOoRrRrRrSsSsSs",  // U+0150
    "SsTtTtTtUuUuUuUu",  // U+0160
    "UuUuWwYyYZzZzZz."   // U+0170
  };

  typedef struct packed {
    cp_t  folded_point;
    logic was_changed;
  } fold_res_t;

endpackage

### design/ldf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_in_if
// Request channel carrying one code point per transfer.
// ----------------------------------------------------------------------------
interface ldf_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;

  modport source (output valid, output code_point, input ready);
  modport sink   (input valid, input code_point, output ready);
endinterface

### design/ldf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_out_if
// Result channel carrying the folded code point and its change flag.
// ----------------------------------------------------------------------------
interface ldf_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] folded_point;
  logic        was_changed;

  modport source (output valid, output folded_point, output was_changed, input ready);
  modport sink   (input valid, input folded_point, input was_changed, output ready);
endinterface

### design/ldf_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_fold
// Table lookup that maps one code point to its ASCII base letter.
// ----------------------------------------------------------------------------
module ldf_fold
  import ldf_pkg::*;
(
  input  cp_t       code_point,
  output fold_res_t res
);

  logic       in_range;
  logic [7:0] idx;
  logic [7:0] ch;

  // Look up the table entry for points inside the covered range
  always_comb begin
    in_range = (code_point >= FoldLo) && (code_point <= FoldHi);
    idx      = 8'(code_point[8:0] - FoldLo[8:0]);
    ch       = FoldMap[(FoldLen - 1 - int'(idx)) * 8 +: 8];
    if (in_range && (ch != NoFold)) begin
      res.folded_point = cp_t'(ch);
      res.was_changed  = 1'b1;
    end else begin
      res.folded_point = code_point;
      res.was_changed  = 1'b0;
    end
  end

endmodule

### design/latin_diacritic_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latin_diacritic_fold
// Folds accented Latin letters of U+00C0..U+017F to their ASCII base letter.
// ----------------------------------------------------------------------------
// One result per request, at one request per cycle while not stalled. A
// request is captured in an input register, looked up in a constant 192-entry
// table, and the result lands in an output register behind it; the input stage
// stalls only while it is full and a result waits at the output. Points
// outside the table or marked unfolded pass through with was_changed low.
module latin_diacritic_fold
  import ldf_pkg::*;
(
  input logic      clk,
  input logic      rst,
  ldf_in_if.sink   din,
  ldf_out_if.source dout
);

  logic      in_valid;
  cp_t       in_cp;
  logic      res_valid;
  fold_res_t res;
  fold_res_t fold_out;
  logic      adv_res;
  logic      adv_in;

  // Advance a stage when it is empty or its contents move on
  assign adv_res   = !res_valid || dout.ready;
  assign adv_in    = !in_valid || adv_res;
  assign din.ready = adv_in;

  // Input register: hold the request code point
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv_in) begin
      in_valid <= din.valid;
    end
    if (adv_in && din.valid) begin
      in_cp <= din.code_point;
    end
  end

  ldf_fold u_fold (
    .code_point (in_cp),
    .res        (fold_out)
  );

  // Result register: hold the folded value until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv_res) begin
      res_valid <= in_valid;
    end
    if (adv_res && in_valid) begin
      res <= fold_out;
    end
  end

  assign dout.valid        = res_valid;
  assign dout.folded_point = res.folded_point;
  assign dout.was_changed  = res.was_changed;

endmodule
